/* hdl/reply_frame_collector_macros.svh */
// Assertion macros for the reply frame collector.
`ifndef REPLY_FRAME_COLLECTOR_MACROS_SVH
`define REPLY_FRAME_COLLECTOR_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off during reset.
`define RFC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, sampled on clk, off during reset.
`define RFC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define RFC_ASSERT_IMP(lbl, ante, cons, msg)
`define RFC_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

/* hdl/rfc_pkg.sv */
// Shared constants, types and helpers for the reply frame collector.
`default_nettype none
package rfc_pkg;

  localparam int MAX_FRAME_BYTES = 32;
  localparam int ADDR_W          = $clog2(MAX_FRAME_BYTES);
  localparam int FILL_W          = $clog2(MAX_FRAME_BYTES + 1);
  localparam int BYTE_W          = 8;
  localparam int INDEX_W         = 5;
  localparam int LEN_W           = 6;

  localparam logic OP_BYTE    = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [BYTE_W-1:0] CH_GT     = 8'h3E;
  localparam logic [BYTE_W-1:0] CH_HASH   = 8'h23;
  localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;

  typedef struct packed {
    logic              opcode;
    logic [BYTE_W-1:0] rx_byte;
  } rfc_in_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  frame_byte;
    logic [INDEX_W-1:0] byte_index;
    logic [LEN_W-1:0]   frame_length;
    logic               last;
  } rfc_out_t;

  // Request from the capture side to start walking a completed frame.
  typedef struct packed {
    logic              start;
    logic [FILL_W-1:0] len;
  } rfc_emit_req_t;

  // Capture-side status.
  typedef struct packed {
    logic              frame_ready;
    logic [FILL_W-1:0] fill;
  } rfc_wr_stat_t;

  function automatic logic is_start_char(input logic [BYTE_W-1:0] b);
    is_start_char = (b == CH_DOLLAR) || (b == CH_GT) || (b == CH_HASH);
  endfunction

endpackage
`default_nettype wire

/* hdl/rfc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* hdl/rfc_wr.sv */
// Capture side: start hunt, byte store writes, fill count and ready flag.
`default_nettype none
module rfc_wr import rfc_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_accept,
  input  wire rfc_in_t              in_data,
  output logic                      we,
  output logic      [ADDR_W-1:0]    waddr,
  output logic      [BYTE_W-1:0]    wdata,
  output rfc_emit_req_t             emit,
  output rfc_wr_stat_t              stat
);

  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              ready_r, ready_nxt;

  always_comb begin
    fill_nxt   = fill_r;
    ready_nxt  = ready_r;
    we         = 1'b0;
    waddr      = fill_r[ADDR_W-1:0];
    wdata      = in_data.rx_byte;
    emit.start = 1'b0;
    emit.len   = fill_r;
    if (in_accept) begin
      if (in_data.opcode == OP_RELEASE) begin
        ready_nxt = 1'b0;
        fill_nxt  = '0;
      end else if (!ready_r) begin
        if (fill_r == '0) begin
          if (is_start_char(in_data.rx_byte)) begin
            we       = 1'b1;
            fill_nxt = FILL_W'(1);
          end
        end else if (in_data.rx_byte == CH_CR) begin
          ready_nxt  = 1'b1;
          emit.start = 1'b1;
        end else if (fill_r < FILL_W'(MAX_FRAME_BYTES)) begin
          we       = 1'b1;
          fill_nxt = fill_r + FILL_W'(1);
        end else begin
          // overflow: drop the frame, the byte is not a new start
          fill_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      ready_r <= 1'b0;
    end else begin
      fill_r  <= fill_nxt;
      ready_r <= ready_nxt;
    end
  end

  assign stat.frame_ready = ready_r;
  assign stat.fill        = fill_r;

endmodule
`default_nettype wire

/* hdl/rfc_rd.sv */
// Emit side: walks the byte store and feeds the result register.
`default_nettype none
module rfc_rd import rfc_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire rfc_emit_req_t        emit,
  input  wire logic                 out_ready,
  input  wire logic [BYTE_W-1:0]    rdata,
  output logic                      re,
  output logic      [ADDR_W-1:0]    raddr,
  output logic                      out_valid,
  output rfc_out_t                  out_data,
  output logic                      busy
);

  logic              walk_r, walk_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  logic [FILL_W-1:0] len_r, len_nxt;
  logic              pend_r;
  logic [ADDR_W-1:0] pend_idx_r;
  logic              pend_last_r;
  logic              oval_r, oval_nxt;
  rfc_out_t          out_r;
  logic              issue;
  logic              is_last;

  assign is_last = (FILL_W'(idx_r) == (len_r - FILL_W'(1)));
  // one read in flight at most; it lands in a result register known free
  assign issue   = walk_r && !pend_r && (!oval_r || out_ready);
  assign re      = issue;
  assign raddr   = idx_r;

  always_comb begin
    walk_nxt = walk_r;
    idx_nxt  = idx_r;
    len_nxt  = len_r;
    if (emit.start) begin
      walk_nxt = 1'b1;
      idx_nxt  = '0;
      len_nxt  = emit.len;
    end else if (issue) begin
      if (is_last) begin
        walk_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + ADDR_W'(1);
      end
    end
  end

  always_comb begin
    oval_nxt = oval_r;
    if (pend_r) begin
      oval_nxt = 1'b1;
    end else if (oval_r && out_ready) begin
      oval_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      walk_r <= 1'b0;
      pend_r <= 1'b0;
      oval_r <= 1'b0;
    end else begin
      walk_r <= walk_nxt;
      pend_r <= issue;
      oval_r <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    len_r <= len_nxt;
    if (issue) begin
      pend_idx_r  <= idx_r;
      pend_last_r <= is_last;
    end
    if (pend_r) begin
      out_r.frame_byte   <= rdata;
      out_r.byte_index   <= INDEX_W'(pend_idx_r);
      out_r.frame_length <= LEN_W'(len_r);
      out_r.last         <= pend_last_r;
    end
  end

  assign out_valid = oval_r;
  assign out_data  = out_r;
  assign busy      = walk_r | pend_r;

endmodule
`default_nettype wire

/* hdl/reply_frame_collector.sv */
// Top level of the reply frame collector: capture, byte store and emit sequencer.
//
//  channel | signals                      | moves
//  --------+------------------------------+-----------------------------------------
//  in      | in_valid in_ready in_data    | one request: received byte or release
//  out     | out_valid out_ready out_data | one frame byte with index, length, last
//
// A received byte or a release is handled by the capture side, which writes the
// store directly. A CR that completes a frame starts the emit sequencer, which reads
// the store one byte per access: each byte is read from the store and loaded into the
// result register before the next read, and new requests wait until the walk is done.
// The store needs no clearing: only entries written in the current frame are read.
// Synchronous active-low reset clears fill count, ready flag and the sequencer.
// A stalled out channel holds the current byte and pauses further store reads.
`default_nettype none
`include "reply_frame_collector_macros.svh"
module reply_frame_collector import rfc_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire rfc_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output rfc_out_t      out_data
);

  logic              in_accept;
  logic              rd_busy;

  // store ports
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;

  rfc_emit_req_t     emit;
  rfc_wr_stat_t      wr_stat;

  // Requests wait only while a frame walk is under way; a finished byte
  // sitting in the result register does not hold the input off.
  assign in_ready  = !rd_busy;
  assign in_accept = in_valid && in_ready;

  rfc_wr u_wr (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .in_data   (in_data),
    .we        (ram_we),
    .waddr     (ram_waddr),
    .wdata     (ram_wdata),
    .emit      (emit),
    .stat      (wr_stat)
  );

  // Frame byte store, one entry per byte position.
  rfc_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_FRAME_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rfc_rd u_rd (
    .clk       (clk),
    .rst_n     (rst_n),
    .emit      (emit),
    .out_ready (out_ready),
    .rdata     (ram_rdata),
    .re        (ram_re),
    .raddr     (ram_raddr),
    .out_valid (out_valid),
    .out_data  (out_data),
    .busy      (rd_busy)
  );

  // A completed frame always holds at least its start character.
  `RFC_ASSERT_IMP(a_emit_nonempty, emit.start, emit.len != '0, "empty frame emitted")
  // Starting a walk keeps new requests off on the next cycle.
  `RFC_ASSERT_NXT(a_emit_busy, emit.start, rd_busy, "walk did not start")
  // The frame stays marked ready for the whole walk.
  `RFC_ASSERT_IMP(a_busy_ready, rd_busy, wr_stat.frame_ready, "walk without ready frame")
  // The fill count never runs past the store.
  `RFC_ASSERT_IMP(a_fill_range, 1'b1, wr_stat.fill <= FILL_W'(MAX_FRAME_BYTES), "fill overrun")
  // The last byte sits at the end of its frame.
  `RFC_ASSERT_IMP(a_last_pos, out_valid && out_data.last,
    out_data.byte_index == INDEX_W'(out_data.frame_length - LEN_W'(1)), "last flag misplaced")

endmodule
`default_nettype wire

/* tb/sv/reply_frame_checker.sv */
// Checker for the reply frame collector: tracks framing state, predicts frame bytes, compares.
`timescale 1ns / 100ps
module reply_frame_checker import rfc_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire logic     in_ready,
  input  wire rfc_in_t  in_data,
  input  wire logic     out_valid,
  input  wire logic     out_ready,
  input  wire rfc_out_t out_data,
  output int            fail_count,
  output int            bytes_owed
);

  logic [BYTE_W-1:0] line_buf [MAX_FRAME_BYTES];
  int                stored_bytes = 0;
  logic              line_held    = 1'b0;
  rfc_out_t          frame_bytes_due [$];
  int                errors       = 0;

  function automatic logic opens_line(input logic [BYTE_W-1:0] b);
    return (b == CH_DOLLAR) || (b == CH_GT) || (b == CH_HASH);
  endfunction

  // Advance the framing state by one accepted request; a CR queues the whole line.
  task automatic take_request(input rfc_in_t req);
    rfc_out_t want;
    if (req.opcode == OP_RELEASE) begin
      line_held    = 1'b0;
      stored_bytes = 0;
    end else if (line_held) begin
      // frame waiting for release: byte dropped
    end else if (stored_bytes == 0) begin
      if (opens_line(req.rx_byte)) begin
        line_buf[0]  = req.rx_byte;
        stored_bytes = 1;
      end
    end else if (req.rx_byte == CH_CR) begin
      line_held = 1'b1;
      for (int i = 0; i < stored_bytes; i++) begin
        want.frame_byte   = line_buf[i];
        want.byte_index   = INDEX_W'(i);
        want.frame_length = LEN_W'(stored_bytes);
        want.last         = (i == stored_bytes - 1);
        frame_bytes_due.push_back(want);
      end
    end else if (stored_bytes < MAX_FRAME_BYTES) begin
      line_buf[stored_bytes] = req.rx_byte;
      stored_bytes++;
    end else begin
      // overflow: line discarded, this byte lost too
      stored_bytes = 0;
    end
  endtask

  always @(posedge clk) begin
    rfc_out_t want;
    if (!rst_n) begin
      stored_bytes = 0;
      line_held    = 1'b0;
      frame_bytes_due.delete();
    end else begin
      // result side first: nothing queued at this edge can already be on the output
      if (out_valid && out_ready) begin
        if (frame_bytes_due.size() == 0) begin
          $display("%0t: unexpected frame byte %h idx %0d len %0d last %b", $time,
                   out_data.frame_byte, out_data.byte_index, out_data.frame_length,
                   out_data.last);
          errors++;
        end else begin
          want = frame_bytes_due.pop_front();
          if (out_data.frame_byte !== want.frame_byte) begin
            $display("%0t: frame_byte expected %h actual %h", $time,
                     want.frame_byte, out_data.frame_byte);
            errors++;
          end
          if (out_data.byte_index !== want.byte_index) begin
            $display("%0t: byte_index expected %0d actual %0d", $time,
                     want.byte_index, out_data.byte_index);
            errors++;
          end
          if (out_data.frame_length !== want.frame_length) begin
            $display("%0t: frame_length expected %0d actual %0d", $time,
                     want.frame_length, out_data.frame_length);
            errors++;
          end
          if (out_data.last !== want.last) begin
            $display("%0t: last expected %b actual %b", $time, want.last, out_data.last);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) take_request(in_data);
    end
    fail_count <= errors;
    bytes_owed <= frame_bytes_due.size();
  end

endmodule

/* tb/sv/tb.sv */
// Testbench top for the reply frame collector: clock, reset, request stimulus, verdict.
`timescale 1ns / 100ps
module tb;
  import rfc_pkg::*;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  rfc_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  rfc_out_t out_data;
  int       fail_count;
  int       bytes_owed;

  // request bookkeeping; junk after a held frame and line noise bytes are not counted
  int requests_done = 0;
  int burst_left    = 0;

  // receiver stall pattern state
  int stall_mode = 0;
  int stall_left = 0;
  int stall_tick = 0;

  reply_frame_collector u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  reply_frame_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .fail_count (fail_count),
    .bytes_owed (bytes_owed)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Receiver: switches at random between always ready, random
  // stalls and a fixed 3-of-7 duty pattern, so stalls hit every byte position.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(16, 80);
    end else begin
      stall_left <= stall_left - 1;
    end
    stall_tick <= stall_tick + 1;
    case (stall_mode)
      0: begin
        out_ready <= 1'b1;
      end
      1: begin
        out_ready <= ($urandom_range(0, 9) < 7);
      end
      default: begin
        out_ready <= ((stall_tick % 7) < 3);
      end
    endcase
  end

  // One request on the in channel. The sender runs in bursts; between bursts
  // valid drops for a random gap (sometimes none, so bursts run back to back).
  // Valid is only lowered after a gap is chosen, never in the step it rises.
  task automatic push_request(input logic op, input logic [BYTE_W-1:0] b,
                              input bit counted);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 5);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= '{opcode: op, rx_byte: b};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (counted) requests_done++;
  endtask

  function automatic logic [BYTE_W-1:0] any_start_char();
    case ($urandom_range(0, 2))
      0:       return CH_DOLLAR;
      1:       return CH_GT;
      default: return CH_HASH;
    endcase
  endfunction

  // Random byte that cannot end a line.
  function automatic logic [BYTE_W-1:0] body_byte();
    logic [BYTE_W-1:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == CH_CR);
    return b;
  endfunction

  // Full line: start char, body, CR, up to two bytes the held frame must ignore,
  // then the release that frees it.
  task automatic push_line(input int body_len);
    int junk;
    push_request(OP_BYTE, any_start_char(), 1'b1);
    repeat (body_len) push_request(OP_BYTE, body_byte(), 1'b1);
    push_request(OP_BYTE, CH_CR, 1'b1);
    junk = $urandom_range(0, 2);
    repeat (junk) begin
      case ($urandom_range(0, 2))
        0:       push_request(OP_BYTE, CH_CR, 1'b0);
        1:       push_request(OP_BYTE, any_start_char(), 1'b0);
        default: push_request(OP_BYTE, 8'($urandom_range(0, 255)), 1'b0);
      endcase
    end
    push_request(OP_RELEASE, 8'($urandom_range(0, 255)), 1'b1);
  endtask

  initial begin
    int seq_no;
    int pick;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // --- directed part ---
    push_request(OP_RELEASE, 8'hFF, 1'b1);   // release with nothing collected
    push_request(OP_BYTE, 8'h00, 1'b1);      // junk while hunting
    push_request(OP_BYTE, 8'hFF, 1'b1);
    push_request(OP_BYTE, CH_CR, 1'b1);      // CR while hunting is just junk
    push_request(OP_BYTE, CH_DOLLAR, 1'b1);
    push_request(OP_BYTE, CH_CR, 1'b1);      // shortest line: start char only
    push_request(OP_BYTE, CH_HASH, 1'b1);    // ignored, frame is held
    push_request(OP_BYTE, CH_CR, 1'b1);      // ignored too, no second emit
    push_request(OP_RELEASE, 8'h00, 1'b1);
    push_request(OP_BYTE, CH_GT, 1'b1);
    push_request(OP_BYTE, 8'h00, 1'b1);
    push_request(OP_BYTE, 8'hFF, 1'b1);
    push_request(OP_BYTE, CH_DOLLAR, 1'b1);  // start char inside the body is data
    push_request(OP_BYTE, CH_CR, 1'b1);
    push_request(OP_RELEASE, 8'h5A, 1'b1);
    push_request(OP_BYTE, CH_HASH, 1'b1);
    push_request(OP_BYTE, 8'h55, 1'b1);
    push_request(OP_RELEASE, 8'hAA, 1'b1);   // partial line thrown away
    push_request(OP_BYTE, 8'h7E, 1'b1);      // back to hunting
    push_request(OP_BYTE, CH_HASH, 1'b1);
    push_request(OP_BYTE, 8'hAA, 1'b1);
    push_request(OP_BYTE, CH_CR, 1'b1);
    push_request(OP_RELEASE, 8'h00, 1'b1);

    // --- random part: mostly well-formed lines with random bodies ---
    seq_no = 0;
    while (requests_done < 210) begin
      pick = $urandom_range(0, 99);
      if (seq_no == 0 || (pick >= 65 && pick < 71)) begin
        // line that exactly fills the store
        push_line(MAX_FRAME_BYTES - 1);
      end else if (seq_no == 1 || (pick >= 71 && pick < 77)) begin
        // overflow: the extra byte kills the line and is not a new start,
        // so the CR after it lands on a hunting block
        push_request(OP_BYTE, any_start_char(), 1'b1);
        repeat (MAX_FRAME_BYTES - 1) push_request(OP_BYTE, body_byte(), 1'b1);
        if ($urandom_range(0, 1)) push_request(OP_BYTE, any_start_char(), 1'b1);
        else push_request(OP_BYTE, body_byte(), 1'b1);
        push_request(OP_BYTE, CH_CR, 1'b1);
      end else if (pick < 55) begin
        push_line($urandom_range(0, 5));
      end else if (pick < 65) begin
        push_line($urandom_range(6, 30));
      end else if (pick < 90) begin
        // broken line: released before its CR
        push_request(OP_BYTE, any_start_char(), 1'b1);
        repeat ($urandom_range(0, 4)) push_request(OP_BYTE, body_byte(), 1'b1);
        push_request(OP_RELEASE, 8'($urandom_range(0, 255)), 1'b1);
      end else begin
        // line noise; may open a line by chance, the release cleans up
        repeat ($urandom_range(1, 3)) push_request(OP_BYTE, 8'($urandom_range(0, 255)), 1'b0);
        push_request(OP_RELEASE, 8'($urandom_range(0, 255)), 1'b1);
      end
      seq_no++;
    end

    in_valid <= 1'b0;
    // let the checker's count catch up with the last accepted request
    @(posedge clk);
    while (bytes_owed != 0) @(posedge clk);
    // quiet window: a 32-byte frame under stalls fits well inside this
    repeat (150) @(posedge clk);
    if (fail_count == 0 && bytes_owed == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
